>>> rtl/dbam_pkg.sv
package dbam_pkg;

  localparam int unsigned MaxTracks = 40;
  localparam int unsigned TrackAw   = $clog2(MaxTracks);
  localparam int unsigned BitmapW   = 24;

  localparam logic [TrackAw-1:0] MaxTrack      = TrackAw'(MaxTracks);
  localparam logic [TrackAw-1:0] DirTrack      = TrackAw'(18);
  localparam logic [5:0]         TrackCountRst = 6'd35;
  localparam logic [13:0]        TotalMax      = 14'h3FFF;

  typedef struct packed {
    logic [7:0]         cnt;
    logic [BitmapW-1:0] bits;
  } entry_t;

  typedef struct packed {
    logic               rd;
    logic               wr;
    logic [TrackAw-1:0] addr;
    entry_t             wdata;
  } mem_req_t;

  typedef enum logic [2:0] {
    K_LOAD    = 3'd0,
    K_TEST    = 3'd1,
    K_ALLOC   = 3'd2,
    K_RELEASE = 3'd3,
    K_FIRST   = 3'd4,
    K_NEAR    = 3'd5,
    K_COUNT   = 3'd6,
    K_REPAIR  = 3'd7
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_TRACK  = 3'd1,
    ST_SECTOR = 3'd2,
    ST_USED   = 3'd3,
    ST_FULL   = 3'd4
  } status_e;

  // sectors per track by zone
  function automatic logic [4:0] zone_sectors(input logic [TrackAw-1:0] t);
    logic [4:0] ns;
    priority if (t <= TrackAw'(17)) begin
      ns = 5'd21;
    end else if (t <= TrackAw'(24)) begin
      ns = 5'd19;
    end else if (t <= TrackAw'(30)) begin
      ns = 5'd18;
    end else begin
      ns = 5'd17;
    end
    return ns;
  endfunction

  function automatic logic [BitmapW-1:0] sector_mask(input logic [4:0] ns);
    logic [BitmapW:0] m;
    m = ({{BitmapW{1'b0}}, 1'b1} << ns) - {{BitmapW{1'b0}}, 1'b1};
    return m[BitmapW-1:0];
  endfunction

endpackage

>>> rtl/dbam_map_mem.sv
module dbam_map_mem (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dbam_pkg::mem_req_t req_i,
  output dbam_pkg::entry_t   rd_data_o
);
  import dbam_pkg::*;

  entry_t               mem_q [MaxTracks];
  logic [MaxTracks-1:0] vld_q;
  entry_t               rdata_q;
  logic                 rvld_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr) begin
      mem_q[req_i.addr] <= req_i.wdata;
    end
    if (req_i.rd) begin
      rdata_q <= mem_q[req_i.addr];
    end
  end

  // entries never written read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (req_i.wr) begin
        vld_q[req_i.addr] <= 1'b1;
      end
      if (req_i.rd) begin
        rvld_q <= vld_q[req_i.addr];
      end
    end
  end

  assign rd_data_o = rvld_q ? rdata_q : '0;

endmodule

>>> rtl/disk_block_allocation_map_top.sv
// Test, allocate, release, track count, rejected beats: S_MOD (S_DONE if rejected) loads the
// out reg. Load entry, repair: each of N usable tracks is read in S_SCAN_RD, checked in
// S_SCAN_CHK; the directory track gets S_SCAN_RD alone. Alloc first/near: likewise per track,
// S_SCAN_RD alone per skip and if none is free; near tries up to 2*(N+1) candidates.
// Reset (rst_ni, async, low): map entries read zero, free total 0, track count 35, no clearing.
// A stalled result parks the block; the next beat is taken once its result is in the out reg.
module disk_block_allocation_map_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         kind_i,
  input  logic [7:0]         track_i,
  input  logic [7:0]         sector_i,
  input  logic [7:0]         entry_count_i,
  input  logic [23:0]        entry_bitmap_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         status_o,
  output logic               block_free_o,
  output logic [5:0]         found_track_o,
  output logic [4:0]         found_sector_o,
  output logic [13:0]        free_pre_o,
  output logic [13:0]        free_post_o,
  output logic signed [14:0] count_o,
  input  logic               cfg_we_i,
  input  logic [5:0]         cfg_wdata_i
);
  import dbam_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_MOD      = 5'b00010,
    S_SCAN_RD  = 5'b00100,
    S_SCAN_CHK = 5'b01000,
    S_DONE     = 5'b10000
  } state_e;

  state_e             state_q, state_d;
  logic [5:0]         tc_q;
  logic [13:0]        total_q, total_d;
  kind_e              kind_q, kind_d;
  logic [7:0]         trk_q, trk_d;
  logic [4:0]         sec_q, sec_d;
  logic [TrackAw-1:0] cur_q, cur_d;
  logic [TrackAw-1:0] dist_q, dist_d;
  logic               side_q, side_d;
  logic [TrackAw-1:0] cand_q, cand_d;
  logic [14:0]        sum_q, sum_d;
  status_e            status_q, status_d;
  logic               bfree_q, bfree_d;
  logic [5:0]         ftrk_q, ftrk_d;
  logic [4:0]         fsec_q, fsec_d;
  logic [13:0]        before_q, before_d;
  logic signed [14:0] cnt_q, cnt_d;

  logic               out_valid_q;
  logic [2:0]         out_status_q;
  logic               out_bfree_q;
  logic [5:0]         out_ftrk_q;
  logic [4:0]         out_fsec_q;
  logic [13:0]        out_before_q, out_after_q;
  logic signed [14:0] out_cnt_q;

  mem_req_t           req;
  entry_t             e;

  logic [TrackAw-1:0] n;
  logic               accept, fin, slot_free, out_load;
  kind_e              in_kind;
  logic               in_trk_ok, in_sec_bad;
  logic [8:0]         near_hi, cand9;
  logic [7:0]         near_lo;
  logic               near_lo_ok, cand_live, cand_elig, scan_end, grab;
  logic [4:0]         ns;
  logic [BitmapW-1:0] masked;
  logic [4:0]         first_s, actual;
  logic               bit_sel;
  logic [7:0]         cnt_dec, cnt_inc;
  logic [13:0]        tot_dec, tot_inc;

  dbam_map_mem u_map (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req),
    .rd_data_o (e)
  );

  assign n          = (tc_q > MaxTrack) ? MaxTrack : tc_q;
  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign in_kind    = kind_e'(kind_i);
  assign in_trk_ok  = (track_i != 8'd0) && (track_i <= {2'b00, n});
  assign in_sec_bad = sector_i >= {3'b000, zone_sectors(track_i[TrackAw-1:0])};

  assign near_hi    = {1'b0, trk_q} + {3'b000, dist_q};
  assign near_lo    = trk_q - {2'b00, dist_q};
  assign near_lo_ok = trk_q > {2'b00, dist_q};
  assign grab       = (kind_q == K_FIRST) || (kind_q == K_NEAR);
  assign cand9      = (kind_q == K_NEAR) ? (side_q ? near_hi : {1'b0, near_lo})
                                         : {3'b000, cur_q};
  assign cand_live  = !((kind_q == K_NEAR) && !side_q && !near_lo_ok);
  assign cand_elig  = cand_live && (cand9 != 9'd0) && (cand9 <= {3'b000, n}) &&
                      (cand9 != {3'b000, DirTrack});
  assign scan_end   = (kind_q == K_NEAR) ? (dist_q > n) : (cur_q > n);

  assign ns     = zone_sectors(cand_q);
  assign masked = e.bits & sector_mask(ns);
  assign actual = 5'($countones(masked));

  always_comb begin
    first_s = '0;
    for (int i = BitmapW - 1; i >= 0; i--) begin
      if (masked[i]) begin
        first_s = 5'(i);
      end
    end
  end

  assign bit_sel = e.bits[sec_q];
  assign cnt_dec = (e.cnt == 8'd0) ? 8'd0 : e.cnt - 8'd1;
  assign cnt_inc = (&e.cnt) ? e.cnt : e.cnt + 8'd1;
  assign tot_dec = (total_q == 14'd0) ? 14'd0 : total_q - 14'd1;
  assign tot_inc = (total_q == TotalMax) ? TotalMax : total_q + 14'd1;

  assign slot_free = !out_valid_q || out_ready_i;
  assign out_load  = fin && slot_free;

  always_comb begin
    state_d  = state_q;
    total_d  = total_q;
    kind_d   = kind_q;
    trk_d    = trk_q;
    sec_d    = sec_q;
    cur_d    = cur_q;
    dist_d   = dist_q;
    side_d   = side_q;
    cand_d   = cand_q;
    sum_d    = sum_q;
    status_d = status_q;
    bfree_d  = bfree_q;
    ftrk_d   = ftrk_q;
    fsec_d   = fsec_q;
    before_d = before_q;
    cnt_d    = cnt_q;
    req      = '0;
    fin      = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          kind_d   = in_kind;
          trk_d    = track_i;
          sec_d    = sector_i[4:0];
          before_d = total_q;
          status_d = ST_OK;
          bfree_d  = 1'b0;
          ftrk_d   = '0;
          fsec_d   = '0;
          cnt_d    = '0;
          cur_d    = TrackAw'(1);
          dist_d   = '0;
          side_d   = 1'b0;
          sum_d    = '0;
          unique case (in_kind)
            K_FIRST, K_NEAR, K_REPAIR: begin
              state_d = S_SCAN_RD;
            end
            default: begin
              if (!in_trk_ok) begin
                status_d = ST_TRACK;
                state_d  = S_DONE;
              end else if ((in_kind == K_TEST || in_kind == K_ALLOC ||
                            in_kind == K_RELEASE) && in_sec_bad) begin
                status_d = ST_SECTOR;
                state_d  = S_DONE;
              end else if (in_kind == K_LOAD) begin
                req.wr    = 1'b1;
                req.addr  = track_i[TrackAw-1:0] - TrackAw'(1);
                req.wdata = '{cnt: entry_count_i, bits: entry_bitmap_i};
                state_d   = S_SCAN_RD;
              end else begin
                req.rd   = 1'b1;
                req.addr = track_i[TrackAw-1:0] - TrackAw'(1);
                state_d  = S_MOD;
              end
            end
          endcase
        end
      end

      S_MOD: begin
        fin      = 1'b1;
        req.addr = trk_q[TrackAw-1:0] - TrackAw'(1);
        unique case (kind_q)
          K_TEST: begin
            bfree_d = bit_sel;
          end
          K_ALLOC: begin
            if (!bit_sel) begin
              status_d = ST_USED;
            end else begin
              req.wr    = 1'b1;
              req.wdata = '{cnt: cnt_dec, bits: e.bits & ~(24'd1 << sec_q)};
              total_d   = tot_dec;
            end
          end
          K_RELEASE: begin
            if (!bit_sel) begin
              req.wr    = 1'b1;
              req.wdata = '{cnt: cnt_inc, bits: e.bits | (24'd1 << sec_q)};
              total_d   = tot_inc;
            end
          end
          K_COUNT: begin
            cnt_d = $signed({7'b0, e.cnt});
          end
          default: ;
        endcase
      end

      S_SCAN_RD: begin
        if (scan_end) begin
          fin = 1'b1;
          if (grab) begin
            status_d = ST_FULL;
          end else begin
            total_d = (sum_q > {1'b0, TotalMax}) ? TotalMax : sum_q[13:0];
          end
        end else begin
          if (kind_q == K_NEAR) begin
            side_d = !side_q;
            if (side_q) begin
              dist_d = dist_q + TrackAw'(1);
            end
          end else begin
            cur_d = cur_q + TrackAw'(1);
          end
          if (cand_elig) begin
            req.rd   = 1'b1;
            req.addr = cand9[TrackAw-1:0] - TrackAw'(1);
            cand_d   = cand9[TrackAw-1:0];
            state_d  = S_SCAN_CHK;
          end
        end
      end

      S_SCAN_CHK: begin
        state_d  = S_SCAN_RD;
        req.addr = cand_q - TrackAw'(1);
        if (kind_q == K_LOAD) begin
          sum_d = sum_q + {7'b0, e.cnt};
        end else if (kind_q == K_REPAIR) begin
          sum_d = sum_q + {10'b0, actual};
          cnt_d = cnt_q + ($signed({10'b0, actual}) - $signed({7'b0, e.cnt}));
          if ({3'b000, actual} != e.cnt) begin
            req.wr    = 1'b1;
            req.wdata = '{cnt: {3'b000, actual}, bits: e.bits};
          end
        end else if (masked != '0) begin
          req.wr    = 1'b1;
          req.wdata = '{cnt: cnt_dec, bits: e.bits & ~(24'd1 << first_s)};
          total_d   = tot_dec;
          ftrk_d    = cand_q;
          fsec_d    = first_s;
          fin       = 1'b1;
        end
      end

      S_DONE: begin
        fin = 1'b1;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (fin) begin
      state_d = slot_free ? S_IDLE : S_DONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      tc_q        <= TrackCountRst;
      total_q     <= '0;
      kind_q      <= K_LOAD;
      cur_q       <= '0;
      dist_q      <= '0;
      side_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      total_q <= total_d;
      kind_q  <= kind_d;
      cur_q   <= cur_d;
      dist_q  <= dist_d;
      side_q  <= side_d;
      if (cfg_we_i) begin
        tc_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    trk_q    <= trk_d;
    sec_q    <= sec_d;
    cand_q   <= cand_d;
    sum_q    <= sum_d;
    status_q <= status_d;
    bfree_q  <= bfree_d;
    ftrk_q   <= ftrk_d;
    fsec_q   <= fsec_d;
    before_q <= before_d;
    cnt_q    <= cnt_d;
    if (out_load) begin
      out_status_q <= status_d;
      out_bfree_q  <= bfree_d;
      out_ftrk_q   <= ftrk_d;
      out_fsec_q   <= fsec_d;
      out_before_q <= before_d;
      out_after_q  <= total_d;
      out_cnt_q    <= cnt_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign block_free_o   = out_bfree_q;
  assign found_track_o  = out_ftrk_q;
  assign found_sector_o = out_fsec_q;
  assign free_pre_o     = out_before_q;
  assign free_post_o    = out_after_q;
  assign count_o        = out_cnt_q;

endmodule

>>> rtl/dbam_checker.sv
module dbam_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [2:0]  status_i,
  input logic        block_free_i,
  input logic [5:0]  found_track_i,
  input logic [4:0]  found_sector_i,
  input logic [13:0] free_pre_i,
  input logic [13:0] free_post_i
);
  import dbam_pkg::*;

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(status_i) &&
    $stable(free_post_i) && $stable(found_track_i))
    else $error("result beat changed while stalled");

  a_err_no_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i != ST_OK) |-> free_post_i == free_pre_i)
    else $error("failed operation changed the free total");

  a_found_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (found_track_i != 6'd0) |->
    (status_i == ST_OK) && (found_track_i != DirTrack) && (found_sector_i < 5'd21))
    else $error("bad block from allocation search");

  a_found_takes_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (found_track_i != 6'd0) |->
    (free_post_i == free_pre_i - 14'd1) ||
    ((free_pre_i == 14'd0) && (free_post_i == 14'd0)))
    else $error("allocation did not take one block from the total");

  a_test_pure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && block_free_i |-> (status_i == ST_OK) && (free_post_i == free_pre_i))
    else $error("block test changed state or failed");

endmodule

bind disk_block_allocation_map_top dbam_checker u_dbam_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .status_i       (status_o),
  .block_free_i   (block_free_o),
  .found_track_i  (found_track_o),
  .found_sector_i (found_sector_o),
  .free_pre_i     (free_pre_o),
  .free_post_i    (free_post_o)
);

>>> sim/tb_disk_block_allocation_map_top.sv
`timescale 1ns / 1ps

module tb_disk_block_allocation_map_top;
  import dbam_pkg::*;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  track;
    logic [7:0]  sector;
    logic [7:0]  ecnt;
    logic [23:0] ebits;
  } op_t;

  typedef struct {
    status_e            status;
    logic               block_free;
    logic [5:0]         ftrk;
    logic [4:0]         fsec;
    logic [13:0]        pre;
    logic [13:0]        post;
    logic signed [14:0] count;
  } reply_t;

  // Mirror of the allocation map and the queue of replies it predicts.
  class alloc_map_check;
    bit [7:0]  free_cnt [MaxTracks];
    bit [23:0] free_map [MaxTracks];
    bit [13:0] free_total;
    bit [5:0]  track_cfg;
    reply_t    want_q [$];
    int        errors;

    function new();
      foreach (free_cnt[i]) begin
        free_cnt[i] = '0;
        free_map[i] = '0;
      end
      free_total = '0;
      track_cfg  = TrackCountRst;
      errors     = 0;
    endfunction

    function int pending();
      return want_q.size();
    endfunction

    function int usable();
      return (track_cfg > MaxTracks) ? MaxTracks : track_cfg;
    endfunction

    function int sectors_on(int t);
      if (t <= 17) return 21;
      if (t <= 24) return 19;
      if (t <= 30) return 18;
      return 17;
    endfunction

    function bit track_valid(int t);
      return t >= 1 && t <= usable();
    endfunction

    function void take_block(int t, int s);
      free_map[t-1][s] = 1'b0;
      if (free_cnt[t-1] != 0) free_cnt[t-1]--;
      if (free_total != 0) free_total--;
    endfunction

    function void recount();
      int sum;
      sum = 0;
      for (int t = 1; t <= usable(); t++) begin
        if (t != DirTrack) sum += free_cnt[t-1];
      end
      free_total = (sum > TotalMax) ? TotalMax : sum[13:0];
    endfunction

    // allocates the lowest free sector of a track, -1 if none
    function int grab(int t);
      if (!track_valid(t) || t == DirTrack) return -1;
      for (int s = 0; s < sectors_on(t); s++) begin
        if (free_map[t-1][s]) begin
          take_block(t, s);
          return s;
        end
      end
      return -1;
    endfunction

    function void note_request(op_t op);
      reply_t r;
      int     trk, sec, s, cnt, actual, n;
      bit     hit;
      trk = int'(op.track);
      sec = int'(op.sector);
      n   = usable();
      cnt = 0;
      hit = 0;
      r.status     = ST_OK;
      r.block_free = 1'b0;
      r.ftrk       = '0;
      r.fsec       = '0;
      r.pre        = free_total;
      case (op.kind)
        K_LOAD, K_TEST, K_ALLOC, K_RELEASE, K_COUNT: begin
          if (!track_valid(trk)) begin
            r.status = ST_TRACK;
          end else if (op.kind inside {K_TEST, K_ALLOC, K_RELEASE} &&
                       sec >= sectors_on(trk)) begin
            r.status = ST_SECTOR;
          end else begin
            case (op.kind)
              K_LOAD: begin
                free_cnt[trk-1] = op.ecnt;
                free_map[trk-1] = op.ebits;
                recount();
              end
              K_TEST: r.block_free = free_map[trk-1][sec];
              K_ALLOC: begin
                if (!free_map[trk-1][sec]) r.status = ST_USED;
                else take_block(trk, sec);
              end
              K_RELEASE: begin
                if (!free_map[trk-1][sec]) begin
                  free_map[trk-1][sec] = 1'b1;
                  if (free_cnt[trk-1] != 8'hFF) free_cnt[trk-1]++;
                  if (free_total != TotalMax) free_total++;
                end
              end
              default: cnt = int'(free_cnt[trk-1]);
            endcase
          end
        end
        K_FIRST: begin
          r.status = ST_FULL;
          for (int t = 1; t <= n && !hit; t++) begin
            s = grab(t);
            if (s >= 0) begin
              hit = 1;
              r.status = ST_OK;
              r.ftrk = 6'(t);
              r.fsec = 5'(s);
            end
          end
        end
        K_NEAR: begin
          r.status = ST_FULL;
          for (int d = 0; d <= n && !hit; d++) begin
            if (trk >= d + 1) begin
              s = grab(trk - d);
              if (s >= 0) begin
                hit = 1;
                r.ftrk = 6'(trk - d);
                r.fsec = 5'(s);
              end
            end
            if (!hit) begin
              s = grab(trk + d);
              if (s >= 0) begin
                hit = 1;
                r.ftrk = 6'(trk + d);
                r.fsec = 5'(s);
              end
            end
          end
          if (hit) r.status = ST_OK;
        end
        default: begin
          for (int t = 1; t <= n; t++) begin
            if (t == DirTrack) continue;
            actual = 0;
            for (int k = 0; k < sectors_on(t); k++) actual += free_map[t-1][k];
            if (actual != free_cnt[t-1]) begin
              cnt += actual - int'(free_cnt[t-1]);
              free_cnt[t-1] = 8'(actual);
            end
          end
          recount();
        end
      endcase
      r.post  = free_total;
      r.count = cnt[14:0];
      want_q.push_back(r);
    endfunction

    task report(string msg);
      $display("%0t mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_reply(reply_t got);
      reply_t w;
      if (want_q.size() == 0) begin
        report("result beat with nothing expected");
        return;
      end
      w = want_q.pop_front();
      if (got.status !== w.status)
        report($sformatf("status %0d, want %0d", got.status, w.status));
      if (got.block_free !== w.block_free)
        report($sformatf("block_free %0b, want %0b", got.block_free, w.block_free));
      if (got.ftrk !== w.ftrk)
        report($sformatf("found_track %0d, want %0d", got.ftrk, w.ftrk));
      if (got.fsec !== w.fsec)
        report($sformatf("found_sector %0d, want %0d", got.fsec, w.fsec));
      if (got.pre !== w.pre)
        report($sformatf("free_pre %0d, want %0d", got.pre, w.pre));
      if (got.post !== w.post)
        report($sformatf("free_post %0d, want %0d", got.post, w.post));
      if (got.count !== w.count)
        report($sformatf("count %0d, want %0d", got.count, w.count));
    endtask
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [2:0]         status_o;
  logic               block_free_o;
  logic [5:0]         found_track_o;
  logic [4:0]         found_sector_o;
  logic [13:0]        free_pre_o;
  logic [13:0]        free_post_o;
  logic signed [14:0] count_o;
  logic               cfg_we_i;
  logic [5:0]         cfg_wdata_i;
  op_t                drv_op;

  alloc_map_check sb = new();
  int unsigned    in_beats;
  int unsigned    send_idle;
  int unsigned    recv_idle;
  int             hold_ask;
  int             hold_seen;
  int             hold_left;

  disk_block_allocation_map_top i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .kind_i         (drv_op.kind),
    .track_i        (drv_op.track),
    .sector_i       (drv_op.sector),
    .entry_count_i  (drv_op.ecnt),
    .entry_bitmap_i (drv_op.ebits),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .block_free_o   (block_free_o),
    .found_track_o  (found_track_o),
    .found_sector_o (found_sector_o),
    .free_pre_o     (free_pre_o),
    .free_post_o    (free_post_o),
    .count_o        (count_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  always #1 clk_i = ~clk_i;

  initial begin
    #4_000_000;
    $display("FAIL");
    $finish;
  end

  always @(posedge clk_i) begin
    reply_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.status     = status_e'(status_o);
      got.block_free = block_free_o;
      got.ftrk       = found_track_o;
      got.fsec       = found_sector_o;
      got.pre        = free_pre_o;
      got.post       = free_post_o;
      got.count      = count_o;
      sb.check_reply(got);
    end
    if (rst_ni && in_valid_i && in_ready_o) begin
      sb.note_request(drv_op);
      in_beats++;
    end
  end

  // result side: random stalls, plus a long hold-off on request
  always @(negedge clk_i) begin
    if (hold_ask != hold_seen) begin
      hold_seen = hold_ask;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      out_ready_i <= 1'b0;
      hold_left--;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic send_item(op_t op);
    int unsigned seen;
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    drv_op     <= op;
    in_valid_i <= 1'b1;
    seen = in_beats;
    wait (in_beats != seen);
  endtask

  task automatic issue(kind_e k, bit [7:0] trk, bit [7:0] sec, bit [7:0] cnt,
                       bit [23:0] bits);
    op_t op;
    op.kind  = k;
    op.track = trk;
    op.sector = sec;
    op.ecnt  = cnt;
    op.ebits = bits;
    send_item(op);
  endtask

  task automatic wait_quiet();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic set_track_count(bit [5:0] v);
    wait_quiet();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.track_cfg = v;
  endtask

  function automatic bit [7:0] free_bits(bit [23:0] bits, int t);
    int c;
    c = 0;
    for (int s = 0; s < sb.sectors_on(t); s++) c += bits[s];
    return c[7:0];
  endfunction

  // fill every usable track: full, sparse, or sparse with wrong counts
  task automatic load_all(int unsigned style);
    bit [23:0] bits;
    bit [7:0]  cnt;
    for (int t = 1; t <= sb.usable(); t++) begin
      bits = (style == 0) ? 24'hFFFFFF : 24'($urandom & $urandom & $urandom);
      cnt  = (style == 2) ? 8'($urandom) : free_bits(bits, t);
      issue(K_LOAD, 8'(t), 8'($urandom), cnt, bits);
    end
  endtask

  function automatic op_t pick_op();
    op_t         op;
    int unsigned sel;
    op.kind   = kind_e'($urandom_range(7));
    op.track  = 8'($urandom);
    op.sector = 8'($urandom);
    op.ecnt   = 8'($urandom);
    op.ebits  = 24'($urandom);
    if ($urandom_range(99) < 10) return op;
    sel = $urandom_range(99);
    op.kind = sel < 8  ? K_LOAD    : sel < 22 ? K_TEST  : sel < 44 ? K_ALLOC :
              sel < 66 ? K_RELEASE : sel < 76 ? K_FIRST : sel < 86 ? K_NEAR  :
              sel < 95 ? K_COUNT   : K_REPAIR;
    if ($urandom_range(99) >= 4) op.track = 8'($urandom_range(sb.usable(), 1));
    if ($urandom_range(99) >= 4)
      op.sector = 8'($urandom_range(sb.sectors_on(op.track) - 1, 0));
    if (op.kind == K_LOAD && $urandom_range(1)) begin
      op.ebits = op.ebits & 24'($urandom);
      op.ecnt  = free_bits(op.ebits, op.track);
    end
    return op;
  endfunction

  initial begin
    bit [5:0] seg_cfg [6];
    seg_cfg     = '{6'd40, 6'd35, 6'd38, 6'd40, 6'd36, 6'd39};
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    drv_op      = '0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    send_idle   = 33;
    recv_idle   = 46;
    hold_ask    = 0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed, at the reset track count
    issue(K_FIRST,   0,   0,   0,   24'h0);
    issue(K_NEAR,    18,  0,   0,   24'h0);
    issue(K_COUNT,   1,   0,   0,   24'h0);
    issue(K_LOAD,    1,   0,   21,  24'h1FFFFF);
    issue(K_LOAD,    18,  0,   19,  24'h07FFFF);
    issue(K_LOAD,    35,  255, 255, 24'hFFFFFF);
    issue(K_LOAD,    36,  0,   5,   24'h00001F);
    issue(K_LOAD,    0,   0,   0,   24'h0);
    issue(K_LOAD,    255, 0,   1,   24'h1);
    issue(K_TEST,    1,   0,   0,   24'h0);
    issue(K_TEST,    1,   21,  0,   24'h0);
    issue(K_TEST,    1,   255, 0,   24'h0);
    issue(K_ALLOC,   1,   0,   0,   24'h0);
    issue(K_ALLOC,   1,   0,   0,   24'h0);
    issue(K_RELEASE, 1,   0,   0,   24'h0);
    issue(K_RELEASE, 1,   0,   0,   24'h0);
    issue(K_RELEASE, 2,   5,   0,   24'h0);
    issue(K_ALLOC,   18,  3,   0,   24'h0);
    issue(K_NEAR,    18,  0,   0,   24'h0);
    issue(K_NEAR,    0,   0,   0,   24'h0);
    issue(K_NEAR,    255, 0,   0,   24'h0);
    issue(K_FIRST,   0,   0,   0,   24'h0);
    issue(K_COUNT,   18,  0,   0,   24'h0);
    issue(K_REPAIR,  0,   0,   0,   24'h0);
    issue(K_LOAD,    35,  0,   0,   24'h0);

    for (int seg = 0; seg < 6; seg++) begin
      set_track_count(seg_cfg[seg]);
      case (seg / 2)
        0: begin
          send_idle = 33;
          recv_idle = 46;
        end
        1: begin
          send_idle = 46;
          recv_idle = 33;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      load_all($urandom_range(2));
      for (int i = 0; i < 180; i++) begin
        if (i == 60 && (seg == 0 || seg == 4)) hold_ask++;
        send_item(pick_op());
      end
    end

    wait_quiet();
    repeat (200) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> disk_block_allocation_map_top.f
rtl/dbam_pkg.sv
rtl/dbam_map_mem.sv
rtl/disk_block_allocation_map_top.sv
rtl/dbam_checker.sv
sim/tb_disk_block_allocation_map_top.sv
